[design/indexed_doubly_linked_queue_core_macros.svh]
// Assertion macros for the indexed doubly linked queue core.
`ifndef INDEXED_DOUBLY_LINKED_QUEUE_CORE_MACROS_SVH
`define INDEXED_DOUBLY_LINKED_QUEUE_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Condition that must hold at every clock edge out of reset
`define IDLQ_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("idlq: invariant violated");

// Condition in one cycle implies a consequence in the same cycle
`define IDLQ_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("idlq: implication violated");

// Condition in one cycle implies a consequence in the next cycle
`define IDLQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("idlq: next-cycle implication violated");

`else

`define IDLQ_ASSERT_ALWAYS(lbl, cond)
`define IDLQ_ASSERT_SAME(lbl, ante, cons)
`define IDLQ_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[design/idlq_pkg.sv]
// Shared types and codes for the indexed doubly linked queue core.
package idlq_pkg;

    // Command codes
    typedef enum logic [1:0] {
        CMD_PUT    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_POP    = 2'd2,
        CMD_QUERY  = 2'd3
    } cmd_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK            = 2'd0,
        ST_PUT_OCCUPIED  = 2'd1,
        ST_REMOVE_ABSENT = 2'd2,
        ST_POP_EMPTY     = 2'd3
    } status_t;

    // Controller to cell row
    typedef struct packed {
        logic sample;     // latch per-cell key match
        logic put_en;     // append new entry at the fill position
        logic remove_en;  // close up the row over the matched cell
        logic pop_en;     // shift the whole row towards the head
    } cell_ctrl_t;

endpackage

[design/idlq_cell.sv]
// One position of the queue row: holds one entry and passes it towards the head.
module idlq_cell
    import idlq_pkg::*;
#(
    parameter int SLOT_BITS    = 6,
    parameter int CNT_BITS     = 7,
    parameter int PAYLOAD_BITS = 32,
    parameter int IDX          = 0
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cell_ctrl_t              ctrl,
    input  logic [CNT_BITS-1:0]     count,
    input  logic [SLOT_BITS-1:0]    key,
    input  logic [PAYLOAD_BITS-1:0] new_a,
    input  logic [PAYLOAD_BITS-1:0] new_b,
    input  logic [SLOT_BITS-1:0]    right_slot,
    input  logic [PAYLOAD_BITS-1:0] right_a,
    input  logic [PAYLOAD_BITS-1:0] right_b,
    input  logic                    shift_in,
    output logic                    shift_out,
    output logic [SLOT_BITS-1:0]    slot_q,
    output logic [PAYLOAD_BITS-1:0] a_q,
    output logic [PAYLOAD_BITS-1:0] b_q
);

    logic                    match_reg;
    logic                    match_next;
    logic [SLOT_BITS-1:0]    slot_reg;
    logic [SLOT_BITS-1:0]    slot_next;
    logic [PAYLOAD_BITS-1:0] a_reg;
    logic [PAYLOAD_BITS-1:0] a_next;
    logic [PAYLOAD_BITS-1:0] b_reg;
    logic [PAYLOAD_BITS-1:0] b_next;
    logic                    valid;
    logic                    load_new;
    logic                    shift_here;

    // Occupancy follows from the fill count: the row is packed from the head
    assign valid      = (count > CNT_BITS'(IDX));
    assign match_next = valid && (slot_reg == key);
    assign load_new   = ctrl.put_en && (count == CNT_BITS'(IDX));

    // Once the matched cell is seen, it and every cell behind it close up
    assign shift_out  = shift_in || match_reg;
    assign shift_here = ctrl.pop_en || (ctrl.remove_en && shift_out);

    // Next contents
    always_comb
    begin
        slot_next = slot_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        if (load_new)
        begin
            slot_next = key;
            a_next    = new_a;
            b_next    = new_b;
        end
        else if (shift_here)
        begin
            slot_next = right_slot;
            a_next    = right_a;
            b_next    = right_b;
        end
    end

    // Match flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else if (ctrl.sample)
        begin
            match_reg <= match_next;
        end
    end

    // Entry contents, meaningful only while valid
    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
    end

    assign slot_q = slot_reg;
    assign a_q    = a_reg;
    assign b_q    = b_reg;

endmodule

[design/idlq_chain.sv]
// Row of queue cells, head at position zero, entries move one place per shift.
module idlq_chain
    import idlq_pkg::*;
#(
    parameter int ENTRIES      = 64,
    parameter int SLOT_BITS    = 6,
    parameter int CNT_BITS     = 7,
    parameter int PAYLOAD_BITS = 32
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cell_ctrl_t              ctrl,
    input  logic [CNT_BITS-1:0]     count,
    input  logic [SLOT_BITS-1:0]    key,
    input  logic [PAYLOAD_BITS-1:0] new_a,
    input  logic [PAYLOAD_BITS-1:0] new_b,
    output logic [SLOT_BITS-1:0]    head_slot,
    output logic [PAYLOAD_BITS-1:0] head_a,
    output logic [PAYLOAD_BITS-1:0] head_b
);

    logic [SLOT_BITS-1:0]    slot_w  [ENTRIES+1];
    logic [PAYLOAD_BITS-1:0] a_w     [ENTRIES+1];
    logic [PAYLOAD_BITS-1:0] b_w     [ENTRIES+1];
    logic                    shift_w [ENTRIES+1];

    // Nothing enters behind the last cell; no shift enters ahead of the head
    assign slot_w[ENTRIES] = '0;
    assign a_w[ENTRIES]    = '0;
    assign b_w[ENTRIES]    = '0;
    assign shift_w[0]      = 1'b0;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        idlq_cell #(
            .SLOT_BITS    (SLOT_BITS),
            .CNT_BITS     (CNT_BITS),
            .PAYLOAD_BITS (PAYLOAD_BITS),
            .IDX          (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .count      (count),
            .key        (key),
            .new_a      (new_a),
            .new_b      (new_b),
            .right_slot (slot_w[i+1]),
            .right_a    (a_w[i+1]),
            .right_b    (b_w[i+1]),
            .shift_in   (shift_w[i]),
            .shift_out  (shift_w[i+1]),
            .slot_q     (slot_w[i]),
            .a_q        (a_w[i]),
            .b_q        (b_w[i])
        );
    end

    assign head_slot = slot_w[0];
    assign head_a    = a_w[0];
    assign head_b    = b_w[0];

endmodule

[design/indexed_doubly_linked_queue_core.sv]
// Indexed queue core: FIFO of slot-tagged entries held in a row of shifting cells.
// Each command passes through key match in every cell, row update and result strobe, in that order.
// A new command is taken in the result cycle, but not during key match or row update (busy high).
// The per-cell match is registered ahead of the row update.
// Reset (rst_n low, asynchronous) empties the queue and clears all membership bits.
// The result strobe lasts one cycle; the receiver cannot stall it.
`include "indexed_doubly_linked_queue_core_macros.svh"

module indexed_doubly_linked_queue_core
    import idlq_pkg::*;
#(
    parameter int ENTRIES      = 64,
    parameter int PAYLOAD_BITS = 32,
    localparam int SLOT_BITS   = $clog2(ENTRIES)
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              command,
    input  logic [SLOT_BITS-1:0]    slot,
    input  logic [PAYLOAD_BITS-1:0] payload_a,
    input  logic [PAYLOAD_BITS-1:0] payload_b,
    output logic                    done,
    output logic [1:0]              status,
    output logic                    slot_member,
    output logic                    is_empty,
    output logic [PAYLOAD_BITS-1:0] out_a,
    output logic [PAYLOAD_BITS-1:0] out_b
);

    localparam int CNT_BITS = $clog2(ENTRIES + 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_MATCH  = 4'b0010,
        S_APPLY  = 4'b0100,
        S_REPORT = 4'b1000
    } state_t;

    state_t                  state_reg;
    state_t                  state_next;
    cmd_t                    cmd_reg;
    logic [SLOT_BITS-1:0]    slot_reg;
    logic [SLOT_BITS-1:0]    slot_wrapped;
    logic [PAYLOAD_BITS-1:0] pa_reg;
    logic [PAYLOAD_BITS-1:0] pb_reg;
    logic [CNT_BITS-1:0]     count_reg;
    logic [CNT_BITS-1:0]     count_next;
    logic [ENTRIES-1:0]      occ_reg;
    logic [ENTRIES-1:0]      occ_next;
    status_t                 status_reg;
    status_t                 status_next;
    logic [PAYLOAD_BITS-1:0] pop_a_reg;
    logic [PAYLOAD_BITS-1:0] pop_b_reg;
    logic [PAYLOAD_BITS-1:0] pop_a_next;
    logic [PAYLOAD_BITS-1:0] pop_b_next;
    logic                    accept;
    logic                    occ_hit;
    logic                    no_entries;
    cell_ctrl_t              ctrl;
    logic [SLOT_BITS-1:0]    head_slot;
    logic [PAYLOAD_BITS-1:0] head_a;
    logic [PAYLOAD_BITS-1:0] head_b;

    assign busy   = (state_reg == S_MATCH) || (state_reg == S_APPLY);
    assign accept = start && !busy;

    // Slot index wraps at the entry count
    assign slot_wrapped = ({1'b0, slot} >= (SLOT_BITS+1)'(ENTRIES))
                        ? slot - SLOT_BITS'(ENTRIES) : slot;

    assign occ_hit    = occ_reg[slot_reg];
    assign no_entries = (count_reg == '0);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   state_next = accept ? S_MATCH : S_IDLE;
            S_MATCH:  state_next = S_APPLY;
            S_APPLY:  state_next = S_REPORT;
            S_REPORT: state_next = accept ? S_MATCH : S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Command decode for the update cycle
    always_comb
    begin
        ctrl        = '0;
        ctrl.sample = (state_reg == S_MATCH);
        count_next  = count_reg;
        occ_next    = occ_reg;
        status_next = status_reg;
        pop_a_next  = pop_a_reg;
        pop_b_next  = pop_b_reg;
        if (state_reg == S_APPLY)
        begin
            status_next = ST_OK;
            case (cmd_reg)
                CMD_PUT:
                begin
                    if (occ_hit)
                    begin
                        status_next = ST_PUT_OCCUPIED;
                    end
                    else
                    begin
                        ctrl.put_en        = 1'b1;
                        count_next         = count_reg + 1'b1;
                        occ_next[slot_reg] = 1'b1;
                    end
                end
                CMD_REMOVE:
                begin
                    if (!occ_hit)
                    begin
                        status_next = ST_REMOVE_ABSENT;
                    end
                    else
                    begin
                        ctrl.remove_en     = 1'b1;
                        count_next         = count_reg - 1'b1;
                        occ_next[slot_reg] = 1'b0;
                    end
                end
                CMD_POP:
                begin
                    if (no_entries)
                    begin
                        status_next = ST_POP_EMPTY;
                        pop_a_next  = '0;
                        pop_b_next  = '0;
                    end
                    else
                    begin
                        ctrl.pop_en         = 1'b1;
                        count_next          = count_reg - 1'b1;
                        occ_next[head_slot] = 1'b0;
                        pop_a_next          = head_a;
                        pop_b_next          = head_b;
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            occ_reg    <= '0;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            occ_reg    <= occ_next;
            status_reg <= status_next;
        end
    end

    // Transaction capture and popped payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= cmd_t'(command);
            slot_reg <= slot_wrapped;
            pa_reg   <= payload_a;
            pb_reg   <= payload_b;
        end
        pop_a_reg <= pop_a_next;
        pop_b_reg <= pop_b_next;
    end

    // Cell row
    idlq_chain #(
        .ENTRIES      (ENTRIES),
        .SLOT_BITS    (SLOT_BITS),
        .CNT_BITS     (CNT_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .count     (count_reg),
        .key       (slot_reg),
        .new_a     (pa_reg),
        .new_b     (pb_reg),
        .head_slot (head_slot),
        .head_a    (head_a),
        .head_b    (head_b)
    );

    // Result, shown for one cycle
    assign done        = (state_reg == S_REPORT);
    assign status      = status_reg;
    assign slot_member = occ_hit;
    assign is_empty    = no_entries;
    assign out_a       = (cmd_reg == CMD_POP) ? pop_a_reg : (no_entries ? '0 : head_a);
    assign out_b       = (cmd_reg == CMD_POP) ? pop_b_reg : (no_entries ? '0 : head_b);

    // Checks
    `IDLQ_ASSERT_ALWAYS(a_count_matches_members, $countones(occ_reg) == count_reg)
    `IDLQ_ASSERT_NEXT(a_put_links_slot, ctrl.put_en, occ_reg[slot_reg] && !no_entries)
    `IDLQ_ASSERT_NEXT(a_remove_clears_member, ctrl.remove_en, !slot_member)
    `IDLQ_ASSERT_SAME(a_no_accept_while_working, busy, !accept)

endmodule
